// ===== src/base10000_decimal_to_scaled_int_top_assert.svh =====
// Assertion macros for the base-10000 decimal decoder.
// Included by the RTL files that carry concurrent assertions; needs no other file.
`ifndef BASE10000_DECIMAL_TO_SCALED_INT_TOP_ASSERT_SVH
`define BASE10000_DECIMAL_TO_SCALED_INT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B10K_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B10K_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/b10k_pkg.sv =====
// Shared constants and helpers for the base-10000 decimal decoder.
// Has no dependencies; used by base10000_decimal_to_scaled_int_top and its testbench.
`timescale 1ns / 1ps

package b10k_pkg;

    localparam int WORD_W    = 16;
    localparam int VALUE_W   = 64;
    localparam int DSCALE_W  = 5;
    localparam int CHUNK_W   = 16;   // width of one digit through the serial MAC
    localparam int MUL_W     = 20;   // widest multiplier constant (10^6)
    localparam int CARRY_W   = 21;
    localparam int DIV_W     = 10;   // widest divisor (1000)
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 72;

    localparam logic [MUL_W-1:0]    BASE_GROUP   = 20'd10000;
    localparam logic [DSCALE_W-1:0] MAX_DSCALE   = 5'd16;
    localparam logic [4:0]          MAX_INT_GRPS = 5'd16;

    // Power of ten for exponents 0..6.
    function automatic logic [MUL_W-1:0] pow10(input logic [2:0] n);
        logic [MUL_W-1:0] p;
        case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== src/base10000_decimal_to_scaled_int_top.sv =====
// Base-10000 packed decimal to scaled 64-bit integer decoder, top level.
// Depends on b10k_pkg and base10000_decimal_to_scaled_int_top_assert.svh.
//
// Channel   Direction  Beat contents
// s_axis    in         tdata[15:0] word, tuser start_req
// m_axis    out        tdata[63:0] scaled_value, tdata[68:64] decimal_scale
//
// A header word is taken in the wait state and needs no further work. A digit word is
// accepted and then sent in four steps through the 16-bit digit-serial multiply-accumulate
// unit (acc * 10000 + digit). Finishing runs one such pass per integer group or padding
// step, then at most one scale-up multiply or one bit-serial divide by 10, 100 or 1000.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A finished result waits in the output register; input beats are taken meanwhile,
// and only a second result stalls until the first one is read.
`timescale 1ns / 1ps

`include "base10000_decimal_to_scaled_int_top_assert.svh"

module base10000_decimal_to_scaled_int_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [b10k_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [15:0] word
    input  logic                               s_axis_tuser,   // [0] start_req
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [b10k_pkg::OUT_DATA_W-1:0]    m_axis_tdata    // [63:0] scaled_value,
                                                               // [68:64] decimal_scale
);

    typedef enum logic [3:0] {
        ST_WAIT, ST_MAC, ST_FIN, ST_FIX_INT, ST_PAD, ST_ADJ, ST_DIVABS, ST_DIV, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        HDR_IDLE, HDR_WEIGHT, HDR_SIGN, HDR_DSCALE, HDR_DIGITS
    } t_hdr;

    t_state r_state;
    t_state r_ret;
    t_hdr   r_hdr;

    logic [15:0]                         r_left;
    logic signed [17:0]                  r_weight;
    logic [19:0]                         r_scale;
    logic [b10k_pkg::DSCALE_W-1:0]       r_dscale;
    logic                                r_neg;
    logic [b10k_pkg::VALUE_W-1:0]        r_acc;
    logic [b10k_pkg::VALUE_W-1:0]        r_add;
    logic [b10k_pkg::MUL_W-1:0]          r_mul;
    logic [b10k_pkg::CARRY_W-1:0]        r_carry;
    logic [1:0]                          r_step;
    logic [4:0]                          r_cnt;
    logic [5:0]                          r_bit;
    logic [b10k_pkg::DIV_W-1:0]          r_rem;
    logic [b10k_pkg::DIV_W-1:0]          r_div;
    logic                                r_dneg;
    logic                                r_out_valid;
    logic [b10k_pkg::VALUE_W-1:0]        r_out_value;
    logic [b10k_pkg::DSCALE_W-1:0]       r_out_scale;

    logic                                w_in_acc;
    logic [36:0]                         w_mac_sum;
    logic [b10k_pkg::DIV_W:0]            w_div_trial;
    logic                                w_div_q;
    logic [b10k_pkg::DIV_W-1:0]          w_div_rem;
    logic                                w_scale_lt;
    logic [4:0]                          w_gap_up;
    logic [19:0]                         w_gap_dn;
    logic                                w_pad;
    logic signed [b10k_pkg::VALUE_W-1:0] w_digit;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_WAIT);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_scale, r_out_value};

    // One 16-bit digit of acc * mul + addend per cycle, low digit first.
    assign w_mac_sum = 37'(r_acc[b10k_pkg::CHUNK_W-1:0]) * 37'(r_mul)
                     + 37'(r_add[b10k_pkg::CHUNK_W-1:0]) + 37'(r_carry);

    // Restoring division step for a constant divisor, one quotient bit per cycle.
    assign w_div_trial = {r_rem, r_acc[b10k_pkg::VALUE_W-1]};
    assign w_div_q     = (w_div_trial >= {1'b0, r_div});
    assign w_div_rem   = w_div_q ? b10k_pkg::DIV_W'(w_div_trial - {1'b0, r_div})
                                 : b10k_pkg::DIV_W'(w_div_trial);

    // Distance between the held scale and the display scale.
    assign w_scale_lt = (r_scale < 20'(r_dscale));
    assign w_gap_up   = r_dscale - r_scale[4:0];
    assign w_gap_dn   = r_scale - 20'(r_dscale);
    assign w_pad      = ((21'(r_scale) + 21'd4) < 21'(r_dscale));

    assign w_digit = 64'(signed'(s_axis_tdata));

    // Header parsing, sequencing of the serial units and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_ret       <= ST_WAIT;
            r_hdr       <= HDR_IDLE;
            r_left      <= '0;
            r_weight    <= '0;
            r_scale     <= '0;
            r_dscale    <= '0;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_step      <= '0;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_dneg      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The output state reloads the register itself when it is read.
            if (r_out_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_WAIT: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser) begin
                            r_left   <= s_axis_tdata[15] ? 16'd0 : s_axis_tdata;
                            r_acc    <= '0;
                            r_scale  <= '0;
                            r_weight <= '0;
                            r_dscale <= '0;
                            r_neg    <= 1'b0;
                            r_hdr    <= HDR_WEIGHT;
                        end else begin
                            case (r_hdr)
                                HDR_WEIGHT: begin
                                    r_weight <= 18'(signed'(s_axis_tdata));
                                    r_scale  <= s_axis_tdata[15]
                                              ? {2'b00, ~s_axis_tdata, 2'b00} : 20'd0;
                                    r_hdr    <= HDR_SIGN;
                                end
                                HDR_SIGN: begin
                                    r_neg <= (s_axis_tdata != 16'd0);
                                    r_hdr <= HDR_DSCALE;
                                end
                                HDR_DSCALE: begin
                                    r_dscale <= (s_axis_tdata > 16'(b10k_pkg::MAX_DSCALE))
                                              ? b10k_pkg::MAX_DSCALE : s_axis_tdata[4:0];
                                    if (r_left == 16'd0) begin
                                        r_hdr   <= HDR_IDLE;
                                        r_state <= ST_FIN;
                                    end else begin
                                        r_hdr <= HDR_DIGITS;
                                    end
                                end
                                HDR_DIGITS: begin
                                    r_mul    <= b10k_pkg::BASE_GROUP;
                                    r_add    <= w_digit;
                                    r_carry  <= '0;
                                    r_step   <= '0;
                                    r_state  <= ST_MAC;
                                    r_weight <= r_weight - 18'sd1;
                                    r_left   <= r_left - 16'd1;
                                    if (r_weight < 0) begin
                                        r_scale <= r_scale + 20'd4;
                                    end
                                    if (r_left == 16'd1) begin
                                        r_hdr <= HDR_IDLE;
                                        r_ret <= ST_FIN;
                                    end else begin
                                        r_ret <= ST_WAIT;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end

                // Four digit steps through the shared multiply-accumulate unit.
                ST_MAC: begin
                    r_acc   <= {w_mac_sum[b10k_pkg::CHUNK_W-1:0],
                                r_acc[b10k_pkg::VALUE_W-1:b10k_pkg::CHUNK_W]};
                    r_add   <= {{b10k_pkg::CHUNK_W{1'b0}},
                                r_add[b10k_pkg::VALUE_W-1:b10k_pkg::CHUNK_W]};
                    r_carry <= w_mac_sum[36:16];
                    r_step  <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= r_ret;
                    end
                end

                // Count the integer groups left out after the last digit.
                ST_FIN: begin
                    r_dneg <= 1'b0;
                    if (r_weight < 0) begin
                        r_cnt <= 5'd0;
                    end else if (r_weight >= 18'sd15) begin
                        r_cnt <= b10k_pkg::MAX_INT_GRPS;
                    end else begin
                        r_cnt <= r_weight[4:0] + 5'd1;
                    end
                    r_state <= ST_FIX_INT;
                end

                ST_FIX_INT: begin
                    if (r_cnt != 5'd0) begin
                        r_cnt   <= r_cnt - 5'd1;
                        r_mul   <= b10k_pkg::BASE_GROUP;
                        r_add   <= '0;
                        r_carry <= '0;
                        r_step  <= '0;
                        r_ret   <= ST_FIX_INT;
                        r_state <= ST_MAC;
                    end else begin
                        r_state <= ST_PAD;
                    end
                end

                // Whole groups of four zeros up to within four digits of the display scale.
                ST_PAD: begin
                    if (w_pad) begin
                        r_scale <= r_scale + 20'd4;
                        r_mul   <= b10k_pkg::BASE_GROUP;
                        r_add   <= '0;
                        r_carry <= '0;
                        r_step  <= '0;
                        r_ret   <= ST_PAD;
                        r_state <= ST_MAC;
                    end else begin
                        r_state <= ST_ADJ;
                    end
                end

                // Final power-of-ten step: multiply up, divide down, or leave the value as it is.
                ST_ADJ: begin
                    if (w_scale_lt && (w_gap_up <= 5'd6)) begin
                        r_mul   <= b10k_pkg::pow10(w_gap_up[2:0]);
                        r_add   <= '0;
                        r_carry <= '0;
                        r_step  <= '0;
                        r_ret   <= ST_OUT;
                        r_state <= ST_MAC;
                    end else if (!w_scale_lt && (w_gap_dn inside {[20'd1:20'd3]})) begin
                        r_div   <= b10k_pkg::DIV_W'(b10k_pkg::pow10(w_gap_dn[2:0]));
                        r_state <= ST_DIVABS;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end

                // Divide the magnitude and restore the sign afterward.
                ST_DIVABS: begin
                    r_dneg  <= r_acc[b10k_pkg::VALUE_W-1];
                    if (r_acc[b10k_pkg::VALUE_W-1]) begin
                        r_acc <= -r_acc;
                    end
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_state <= ST_DIV;
                end

                ST_DIV: begin
                    r_rem <= w_div_rem;
                    r_acc <= {r_acc[b10k_pkg::VALUE_W-2:0], w_div_q};
                    r_bit <= r_bit + 6'd1;
                    if (r_bit == 6'd63) begin
                        r_state <= ST_OUT;
                    end
                end

                // Load the result once the output register is free.
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_value <= (r_neg ^ r_dneg) ? -r_acc : r_acc;
                        r_out_scale <= r_dscale;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_WAIT;
                    end
                end

                default: begin
                    r_state <= ST_WAIT;
                end
            endcase
        end
    end

    // A result appears only from the output-load state.
    `B10K_ASSERT_IMP(a_out_from_load, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == ST_OUT, "result loaded outside the output state")
    // An accepted digit word always starts the multiply-accumulate unit.
    `B10K_ASSERT_NXT(a_digit_starts_mac, i_clk, i_rst_n,
        w_in_acc && !s_axis_tuser && (r_hdr == HDR_DIGITS),
        (r_state == ST_MAC) && (r_step == 2'd0), "digit word did not start the MAC")
    // The division remainder stays below the divisor.
    `B10K_ASSERT_IMP(a_div_rem_bound, i_clk, i_rst_n, r_state == ST_DIV,
        r_rem < r_div, "division remainder out of range")

endmodule

// ===== tb/base10000_decimal_to_scaled_int_top_test.sv =====
// Self-checking testbench for the base-10000 packed decimal to scaled integer decoder.
// Depends on b10k_pkg and base10000_decimal_to_scaled_int_top; a scoreboard class
// predicts each decoded value while plain tasks drive and stall the input stream.
`timescale 1ns / 1ps

module base10000_decimal_to_scaled_int_top_test;

    localparam int DRAIN_CYCLES = 400;
    localparam longint TIMEOUT_NS = 64'd16_000_000;
    localparam int MAX_REPORTS = 10;

    // Where the decoder stands within one encoded value.
    typedef enum logic [2:0] {
        HDR_IDLE,
        HDR_WEIGHT,
        HDR_SIGN,
        HDR_DSCALE,
        HDR_DIGITS
    } t_hdr_pos;

    typedef struct packed {
        logic [b10k_pkg::VALUE_W-1:0]  value;
        logic [b10k_pkg::DSCALE_W-1:0] scale;
    } t_decoded;

    // Tracks the decoder state word by word and queues the decoded values.
    class t_decimal_scoreboard;
        t_hdr_pos           position;
        logic [15:0]        digits_left;
        int                 weight;
        int                 frac_digits;
        logic [4:0]         dscale;
        bit                 negative;
        logic [63:0]        acc;
        t_decoded           pending_decodes[$];
        int unsigned        error_count;
        int unsigned        values_checked;

        function new();
            position = HDR_IDLE;
            digits_left = '0;
            weight = 0;
            frac_digits = 0;
            dscale = '0;
            negative = 1'b0;
            acc = '0;
            error_count = 0;
            values_checked = 0;
        endfunction

        // Signed divide that truncates toward zero, on a two's complement value.
        function logic [63:0] div_toward_zero(logic [63:0] v, logic [63:0] d);
            if (v[63]) begin
                return -((-v) / d);
            end
            return v / d;
        endfunction

        // Pads missing integer groups, rescales to the display scale and applies the sign.
        function t_decoded finish_value();
            t_decoded    res;
            logic [63:0] v;
            int         s;
            int         ds;
            int         groups;
            v = acc;
            s = frac_digits;
            ds = int'(dscale);
            if (weight >= 0) begin
                groups = weight + 1;
                if (groups > int'(b10k_pkg::MAX_INT_GRPS)) begin
                    groups = int'(b10k_pkg::MAX_INT_GRPS);
                end
                repeat (groups) v = v * b10k_pkg::BASE_GROUP;
            end
            while (s < ds - 4) begin
                v = v * b10k_pkg::BASE_GROUP;
                s += 4;
            end
            case (s - ds)
                -6: v = v * 64'd1000000;
                -5: v = v * 64'd100000;
                -4: v = v * 64'd10000;
                -3: v = v * 64'd1000;
                -2: v = v * 64'd100;
                -1: v = v * 64'd10;
                1: v = div_toward_zero(v, 64'd10);
                2: v = div_toward_zero(v, 64'd100);
                3: v = div_toward_zero(v, 64'd1000);
                default: ;
            endcase
            if (negative) begin
                v = -v;
            end
            res.value = v;
            res.scale = dscale;
            position = HDR_IDLE;
            return res;
        endfunction

        // Called for every accepted input beat.
        function void note_word(logic [15:0] w, logic start);
            int sw;
            sw = int'($signed(w));
            if (start) begin
                digits_left = (sw > 0) ? w : 16'd0;
                acc = '0;
                frac_digits = 0;
                weight = 0;
                dscale = '0;
                negative = 1'b0;
                position = HDR_WEIGHT;
                return;
            end
            case (position)
                HDR_WEIGHT: begin
                    weight = sw;
                    frac_digits = (sw < 0) ? -(sw + 1) * 4 : 0;
                    position = HDR_SIGN;
                end
                HDR_SIGN: begin
                    negative = (w != 16'd0);
                    position = HDR_DSCALE;
                end
                HDR_DSCALE: begin
                    dscale = (w > 16'(b10k_pkg::MAX_DSCALE)) ? b10k_pkg::MAX_DSCALE : w[4:0];
                    if (digits_left == 16'd0) begin
                        pending_decodes.insert(pending_decodes.size(), finish_value());
                    end else begin
                        position = HDR_DIGITS;
                    end
                end
                HDR_DIGITS: begin
                    acc = acc * b10k_pkg::BASE_GROUP + longint'($signed(w));
                    if (weight < 0) begin
                        frac_digits += 4;
                    end
                    weight -= 1;
                    digits_left -= 16'd1;
                    if (digits_left == 16'd0) begin
                        pending_decodes.insert(pending_decodes.size(), finish_value());
                    end
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted output beat.
        function void check_result(logic [b10k_pkg::OUT_DATA_W-1:0] beat);
            t_decoded                      want;
            logic [b10k_pkg::VALUE_W-1:0]  got_value;
            logic [b10k_pkg::DSCALE_W-1:0] got_scale;
            got_value = beat[b10k_pkg::VALUE_W-1:0];
            got_scale = beat[b10k_pkg::VALUE_W+b10k_pkg::DSCALE_W-1:b10k_pkg::VALUE_W];
            if (pending_decodes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%t: unexpected result beat value=%h scale=%0d",
                             $realtime, got_value, got_scale);
                end
                return;
            end
            want = pending_decodes.pop_front();
            values_checked++;
            if (got_value !== want.value || got_scale !== want.scale) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%t: mismatch value exp=%h got=%h, scale exp=%0d got=%0d",
                             $realtime, want.value, got_value, want.scale, got_scale);
                end
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [b10k_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;    // [15:0] word
    logic                            s_axis_tuser = 1'b0;  // [0] start_req
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [b10k_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // [63:0] scaled_value, [68:64] decimal_scale

    t_decimal_scoreboard sb;
    int send_idle_pct = 18;
    int recv_idle_pct = 72;
    int unsigned counted_words = 0;
    int unsigned ignored_words = 0;
    logic [15:0] digit_script[$];

    base10000_decimal_to_scaled_int_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Random back-pressure on the result stream.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Beat monitor: results are checked before the input of the same edge is noted,
    // since a result can only come from words taken at earlier edges.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_word(s_axis_tdata, s_axis_tuser);
            end
        end
    end

    // Offers one word, with random idle cycles first, and waits for its beat.
    task automatic push_word(input logic [15:0] w, input logic start, input bit counts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tuser <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (counts) begin
            counted_words++;
        end else begin
            ignored_words++;
        end
    endtask

    function automatic logic [15:0] pick_digit(input int digit_style);
        case (digit_style)
            0: return 16'($urandom_range(9999));
            1: begin
                case ($urandom_range(9))
                    0: return 16'd0;
                    1: return 16'd9999;
                    2: return 16'($urandom_range(65535));
                    default: return 16'($urandom_range(9999));
                endcase
            end
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Sends one encoded value. A stop_after of zero or more cuts it short after that
    // many words past the digit count, so the next start drops it.
    task automatic send_decimal(input logic [15:0] count_w, input logic [15:0] weight_w,
                                input logic [15:0] sign_w, input logic [15:0] dscale_w,
                                input int digit_style, input int stop_after);
        int total;
        logic [15:0] w;
        total = 3 + (($signed(count_w) > 0) ? int'(count_w) : 0);
        push_word(count_w, 1'b1, 1'b1);
        for (int k = 0; k < total; k++) begin
            if (stop_after >= 0 && k >= stop_after) begin
                break;
            end
            case (k)
                0: w = weight_w;
                1: w = sign_w;
                2: w = dscale_w;
                default: w = (digit_script.size() != 0) ? digit_script.pop_front()
                                                        : pick_digit(digit_style);
            endcase
            push_word(w, 1'b0, 1'b1);
        end
    endtask

    // Mostly well-formed values of a few digits, with wide headers, empty values,
    // dropped values, idle noise and a few long values mixed in.
    task automatic random_values(input int unsigned target);
        int unsigned first;
        int          pick;
        bit          dropped;
        logic [15:0] sgn;
        first = counted_words;
        dropped = 1'b0;
        while (counted_words - first < target) begin
            pick = $urandom_range(99);
            sgn = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 65535));
            if (pick < 72) begin
                send_decimal(16'($urandom_range(1, 6)), 16'($signed($urandom_range(9)) - 4),
                             sgn, 16'($urandom_range(20)), 1, -1);
                dropped = 1'b0;
            end else if (pick < 79) begin
                send_decimal($urandom_range(1) ? 16'd0 : 16'($urandom_range(32768, 65535)),
                             16'($urandom_range(65535)), sgn,
                             16'($urandom_range(65535)), 0, -1);
                dropped = 1'b0;
            end else if (pick < 86) begin
                send_decimal(16'($urandom_range(1, 4)), 16'($urandom_range(65535)), sgn,
                             16'($urandom_range(65535)), 2, -1);
                dropped = 1'b0;
            end else if (pick < 93) begin
                send_decimal($urandom_range(3) == 0 ? 16'h7FFF : 16'($urandom_range(6, 32767)),
                             16'($urandom_range(65535)), sgn, 16'($urandom_range(65535)), 2,
                             $urandom_range(8));
                dropped = 1'b1;
            end else if (pick < 97) begin
                // Words with no start while idle are dropped by the block.
                if (!dropped) begin
                    repeat ($urandom_range(1, 3)) begin
                        push_word(16'($urandom_range(65535)), 1'b0, 1'b0);
                    end
                end
            end else begin
                send_decimal(16'($urandom_range(20, 40)), 16'($signed($urandom_range(50)) - 25),
                             sgn, 16'($urandom_range(20)), 1, -1);
                dropped = 1'b0;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed values: empty, negative count with clamped scale and saturated
        // integer groups, extreme digits, padding, idle noise, a dropped value and
        // a truncating divide of a negative value.
        send_decimal(16'd0, 16'd0, 16'd0, 16'd0, 0, -1);
        send_decimal(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 0, -1);
        digit_script = '{16'd9999, 16'h8000};
        send_decimal(16'd2, 16'h8000, 16'd1, 16'd3, 0, -1);
        digit_script = '{16'h7FFF};
        send_decimal(16'd1, 16'd0, 16'd0, 16'd16, 0, -1);
        push_word(16'hFFFF, 1'b0, 1'b0);
        send_decimal(16'h7FFF, 16'hFFFF, 16'd0, 16'd0, 0, 1);
        digit_script = '{16'd1234, 16'd5679};
        send_decimal(16'd2, 16'd0, 16'h8000, 16'd1, 0, -1);

        random_values(560);
        send_idle_pct = 72;
        recv_idle_pct <= 18;
        random_values(560);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_values(560);
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every decoded value, then watch for stray beats.
        while (sb.pending_decodes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d encoded words plus %0d idle words; checked %0d decoded values.",
                 counted_words, ignored_words, sb.values_checked);
        $display("Mismatches and unexpected beats: %0d.", sb.error_count);
        if (sb.error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop in case the decoder hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/b10k_pkg.sv
src/base10000_decimal_to_scaled_int_top.sv
tb/base10000_decimal_to_scaled_int_top_test.sv
